// ===== sv/nir_pkg.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types, register codes, reset values and the duration match function.
// ----------------------------------------------------------------------------
`default_nettype none

package nir_pkg;

  localparam int NirMaxSymbols    = 64;
  localparam int NirFullSymbols   = 34;
  localparam int NirRepeatSymbols = 2;
  localparam int NirHalfBits      = 16;

  localparam int NirDurW  = 15;
  localparam int NirTolW  = 10;
  localparam int NirCfgW  = 15;
  localparam int NirIdxCW = 3;

  localparam logic [NirTolW-1:0] NirRstTolerance   = 10'd200;
  localparam logic [NirDurW-1:0] NirRstLeaderMark  = 15'd9000;
  localparam logic [NirDurW-1:0] NirRstLeaderSpace = 15'd4500;
  localparam logic [NirDurW-1:0] NirRstRepeatSpace = 15'd2250;
  localparam logic [NirDurW-1:0] NirRstBitMark     = 15'd560;
  localparam logic [NirDurW-1:0] NirRstZeroSpace   = 15'd560;
  localparam logic [NirDurW-1:0] NirRstOneSpace    = 15'd1690;

  typedef enum logic [1:0] {
    StatusValid   = 2'd0,
    StatusRepeat  = 2'd1,
    StatusInvalid = 2'd2
  } status_e;

  typedef enum logic [NirIdxCW-1:0] {
    CfgTolerance   = 3'd0,
    CfgLeaderMark  = 3'd1,
    CfgLeaderSpace = 3'd2,
    CfgRepeatSpace = 3'd3,
    CfgBitMark     = 3'd4,
    CfgZeroSpace   = 3'd5,
    CfgOneSpace    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [NirDurW-1:0] mark_duration;
    logic [NirDurW-1:0] space_duration;
    logic               last_symbol;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] address;
    logic [15:0] command;
  } out_item_t;

  // Strictly inside (spec - tol, spec + tol); a lower bound below zero never matches.
  function automatic logic near_spec(logic [NirDurW-1:0] meas,
                                     logic [NirDurW-1:0] spec,
                                     logic [NirTolW-1:0] tol);
    logic [NirDurW:0] upper;
    logic [NirDurW:0] lower;
    upper = {1'b0, spec} + {{(NirDurW+1-NirTolW){1'b0}}, tol};
    lower = {1'b0, spec} - {{(NirDurW+1-NirTolW){1'b0}}, tol};
    return ({{(NirDurW-NirTolW){1'b0}}, tol} <= spec) &&
           ({1'b0, meas} < upper) && ({1'b0, meas} > lower);
  endfunction

endpackage

`default_nettype wire

// ===== sv/nec_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Checks one mark/space symbol per item and reports one result per frame.
// ----------------------------------------------------------------------------
// The result of a frame is registered and shows in the cycle after its last symbol is taken.
// Throughput: one symbol per cycle; the result register is the only buffer, so
// input stalls only while a result waits and the output side stalls.
// Reset: frame state, stored address/command and the output valid flag clear at
// once; timing registers return to the standard NEC values.
`default_nettype none

module nec_ir_frame_decoder
  import nir_pkg::*;
#(
  parameter int MaxSymbols = NirMaxSymbols
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [NirIdxCW-1:0] cfg_index_i,
  input  wire logic [NirCfgW-1:0]  cfg_data_i
);

  localparam int IdxW = $clog2(MaxSymbols + 1);

  // timing registers
  logic [NirTolW-1:0] tol_q;
  logic [NirDurW-1:0] leader_mark_q, leader_space_q, repeat_space_q;
  logic [NirDurW-1:0] bit_mark_q, zero_space_q, one_space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q          <= NirRstTolerance;
      leader_mark_q  <= NirRstLeaderMark;
      leader_space_q <= NirRstLeaderSpace;
      repeat_space_q <= NirRstRepeatSpace;
      bit_mark_q     <= NirRstBitMark;
      zero_space_q   <= NirRstZeroSpace;
      one_space_q    <= NirRstOneSpace;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTolerance:   tol_q          <= cfg_data_i[NirTolW-1:0];
        CfgLeaderMark:  leader_mark_q  <= cfg_data_i;
        CfgLeaderSpace: leader_space_q <= cfg_data_i;
        CfgRepeatSpace: repeat_space_q <= cfg_data_i;
        CfgBitMark:     bit_mark_q     <= cfg_data_i;
        CfgZeroSpace:   zero_space_q   <= cfg_data_i;
        CfgOneSpace:    one_space_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state
  logic [IdxW-1:0] sym_idx_q, sym_idx_d;
  logic            good_q, good_d;
  logic            rpt_q, rpt_d;
  logic [15:0]     addr_sh_q, addr_sh_d, cmd_sh_q, cmd_sh_d;
  logic [15:0]     saved_addr_q, saved_addr_d, saved_cmd_q, saved_cmd_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_data_q, out_data_d;

  logic            accept;
  logic            lead_ok, rpt_ok, bit_mark_ok, one_ok, zero_ok;
  logic [IdxW-1:0] pos_m1;
  logic [3:0]      bit_sel;
  logic [15:0]     bit_mask;
  logic            full_frame, rpt_frame;
  status_e         status;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign lead_ok     = near_spec(in_data_i.mark_duration, leader_mark_q, tol_q);
  assign rpt_ok      = lead_ok &&
                       near_spec(in_data_i.space_duration, repeat_space_q, tol_q);
  assign bit_mark_ok = near_spec(in_data_i.mark_duration, bit_mark_q, tol_q);
  assign one_ok      = bit_mark_ok &&
                       near_spec(in_data_i.space_duration, one_space_q, tol_q);
  assign zero_ok     = bit_mark_ok &&
                       near_spec(in_data_i.space_duration, zero_space_q, tol_q);

  // address and command bits share the same low four index bits
  assign pos_m1   = sym_idx_q - IdxW'(1);
  assign bit_sel  = pos_m1[3:0];
  assign bit_mask = 16'(1) << bit_sel;

  always_comb begin
    sym_idx_d = sym_idx_q;
    good_d    = good_q;
    rpt_d     = rpt_q;
    addr_sh_d = addr_sh_q;
    cmd_sh_d  = cmd_sh_q;
    if (sym_idx_q >= IdxW'(MaxSymbols)) begin
      // overlong frame: drop the symbol
      good_d = 1'b0;
      rpt_d  = 1'b0;
    end else begin
      sym_idx_d = sym_idx_q + IdxW'(1);
      if (sym_idx_q == '0) begin
        if (!(lead_ok && near_spec(in_data_i.space_duration, leader_space_q, tol_q))) begin
          good_d = 1'b0;
        end
        rpt_d = rpt_ok;
      end else if (sym_idx_q <= IdxW'(2 * NirHalfBits)) begin
        if (one_ok) begin
          if (sym_idx_q <= IdxW'(NirHalfBits)) begin
            addr_sh_d = addr_sh_q | bit_mask;
          end else begin
            cmd_sh_d = cmd_sh_q | bit_mask;
          end
        end else if (!zero_ok) begin
          good_d = 1'b0;
        end
      end
    end
  end

  assign full_frame = (sym_idx_q == IdxW'(NirFullSymbols - 1)) && good_d;
  assign rpt_frame  = (sym_idx_q == IdxW'(NirRepeatSymbols - 1)) && rpt_d;

  always_comb begin
    priority if (full_frame) begin
      status = StatusValid;
    end else if (rpt_frame) begin
      status = StatusRepeat;
    end else begin
      status = StatusInvalid;
    end
  end

  always_comb begin
    saved_addr_d = saved_addr_q;
    saved_cmd_d  = saved_cmd_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    if (accept && in_data_i.last_symbol) begin
      if (full_frame) begin
        saved_addr_d = addr_sh_d;
        saved_cmd_d  = cmd_sh_d;
      end
      out_valid_d        = 1'b1;
      out_data_d.status  = status;
      out_data_d.address = saved_addr_d;
      out_data_d.command = saved_cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_idx_q    <= '0;
      good_q       <= 1'b1;
      rpt_q        <= 1'b0;
      addr_sh_q    <= '0;
      cmd_sh_q     <= '0;
      saved_addr_q <= '0;
      saved_cmd_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        saved_addr_q <= saved_addr_d;
        saved_cmd_q  <= saved_cmd_d;
        if (in_data_i.last_symbol) begin
          // start a fresh frame
          sym_idx_q <= '0;
          good_q    <= 1'b1;
          rpt_q     <= 1'b0;
          addr_sh_q <= '0;
          cmd_sh_q  <= '0;
        end else begin
          sym_idx_q <= sym_idx_d;
          good_q    <= good_d;
          rpt_q     <= rpt_d;
          addr_sh_q <= addr_sh_d;
          cmd_sh_q  <= cmd_sh_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/nir_checker.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder checker
// Port-level checks on result timing and flow control, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nir_checker
  import nir_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire in_item_t            in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire out_item_t           out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a last symbol always yields a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_symbol |=> out_valid_o)
    else $error("no result after last symbol");

  // a middle symbol into an empty output yields nothing
  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_data_i.last_symbol && !out_valid_o |=> !out_valid_o)
    else $error("result without last symbol");

  // a waiting, stalled result blocks the input
  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result blocked");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder nir_checker u_nir_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Sends mark/space symbols through the valid/stall input channel and predicts
// each frame result (valid, repeat or invalid, with the stored address and
// command) in a model kept inside the bench. Each result taken from the output
// channel is checked field by field. The run covers the default timing, the
// match window edges, extreme timing registers, a long output hold-off and
// random frames under random pacing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import nir_pkg::*;
();

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [NirIdxCW-1:0] cfg_index_i = '0;
  logic [NirCfgW-1:0]  cfg_data_i  = '0;

  nec_ir_frame_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Timing registers as the decoder should hold them
  int unsigned tol_q          = NirRstTolerance;
  int unsigned leader_mark_q  = NirRstLeaderMark;
  int unsigned leader_space_q = NirRstLeaderSpace;
  int unsigned repeat_space_q = NirRstRepeatSpace;
  int unsigned bit_mark_q     = NirRstBitMark;
  int unsigned zero_space_q   = NirRstZeroSpace;
  int unsigned one_space_q    = NirRstOneSpace;

  // Frame state of the decoder
  int unsigned sym_count  = 0;
  bit          frame_ok   = 1'b1;
  bit          rpt_seen   = 1'b0;
  logic [15:0] addr_acc   = '0;
  logic [15:0] cmd_acc    = '0;
  logic [15:0] addr_saved = '0;
  logic [15:0] cmd_saved  = '0;

  out_item_t   expected_frames[$];
  out_item_t   exp_frame;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;

  // Pacing of both channels
  int unsigned gap_max    = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_run  = 0;
  int unsigned hold_left  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall runs, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
      stall_run = $urandom_range(5, 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result status=%0d address=%h command=%h", $time,
                 out_data_o.status, out_data_o.address, out_data_o.command);
        mismatches++;
      end else begin
        exp_frame = expected_frames.pop_front();
        if (out_data_o.status !== exp_frame.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_frame.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.address !== exp_frame.address) begin
          $display("%0t: address expected %h actual %h", $time,
                   exp_frame.address, out_data_o.address);
          mismatches++;
        end
        if (out_data_o.command !== exp_frame.command) begin
          $display("%0t: command expected %h actual %h", $time,
                   exp_frame.command, out_data_o.command);
          mismatches++;
        end
      end
    end
  end

  // Bounds are 32-bit unsigned, so a tolerance above the spec never matches
  function automatic bit in_window(int unsigned meas, int unsigned spec);
    return (meas < spec + tol_q) && (meas > spec - tol_q);
  endfunction

  task automatic decode_symbol(input in_item_t it);
    int unsigned mark;
    int unsigned space;
    int unsigned pos;
    int unsigned count;
    bit          one_hit;
    bit          zero_hit;
    out_item_t   r;
    mark  = it.mark_duration;
    space = it.space_duration;
    if (sym_count >= NirMaxSymbols) begin
      frame_ok = 1'b0;
      rpt_seen = 1'b0;
    end else begin
      pos = sym_count;
      if (pos == 0) begin
        if (!(in_window(mark, leader_mark_q) && in_window(space, leader_space_q)))
          frame_ok = 1'b0;
        rpt_seen = in_window(mark, leader_mark_q) && in_window(space, repeat_space_q);
      end else if (pos <= 2 * NirHalfBits) begin
        one_hit  = in_window(mark, bit_mark_q) && in_window(space, one_space_q);
        zero_hit = in_window(mark, bit_mark_q) && in_window(space, zero_space_q);
        // A one wins over a zero when both windows match
        if (one_hit) begin
          if (pos <= NirHalfBits) addr_acc[pos-1] = 1'b1;
          else cmd_acc[pos-1-NirHalfBits] = 1'b1;
        end else if (!zero_hit) begin
          frame_ok = 1'b0;
        end
      end
    end
    count = sym_count + 1;
    if (sym_count < NirMaxSymbols) sym_count++;
    if (it.last_symbol) begin
      if (count == NirFullSymbols && frame_ok) begin
        addr_saved = addr_acc;
        cmd_saved  = cmd_acc;
        r.status   = StatusValid;
      end else if (count == NirRepeatSymbols && rpt_seen) begin
        r.status = StatusRepeat;
      end else begin
        r.status = StatusInvalid;
      end
      r.address = addr_saved;
      r.command = cmd_saved;
      expected_frames.push_back(r);
      sym_count = 0;
      frame_ok  = 1'b1;
      rpt_seen  = 1'b0;
      addr_acc  = '0;
      cmd_acc   = '0;
    end
  endtask

  task automatic send_symbol(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = $urandom_range(gap_max, 0);
      burst_left = $urandom_range(16, 1);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_symbol(it);
    items_sent++;
    burst_left--;
  endtask

  // Drop valid, then let every pending result drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= NirCfgW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTolerance:   tol_q          = value & 32'h3FF;
      CfgLeaderMark:  leader_mark_q  = value & 32'h7FFF;
      CfgLeaderSpace: leader_space_q = value & 32'h7FFF;
      CfgRepeatSpace: repeat_space_q = value & 32'h7FFF;
      CfgBitMark:     bit_mark_q     = value & 32'h7FFF;
      CfgZeroSpace:   zero_space_q   = value & 32'h7FFF;
      CfgOneSpace:    one_space_q    = value & 32'h7FFF;
      default: ;
    endcase
  endtask

  task automatic set_timing(input int unsigned tol, lm, ls, rs, bm, zs, os);
    write_reg(CfgTolerance, tol);
    write_reg(CfgLeaderMark, lm);
    write_reg(CfgLeaderSpace, ls);
    write_reg(CfgRepeatSpace, rs);
    write_reg(CfgBitMark, bm);
    write_reg(CfgZeroSpace, zs);
    write_reg(CfgOneSpace, os);
  endtask

  // A duration that matches spec, often right at a window edge; any value
  // when no duration can match
  function automatic logic [NirDurW-1:0] pick_near(input int unsigned spec);
    int lo;
    int hi;
    if (tol_q == 0 || tol_q > spec) return NirDurW'($urandom);
    lo = int'(spec) - int'(tol_q) + 1;
    hi = int'(spec) + int'(tol_q) - 1;
    if (hi > 32767) hi = 32767;
    case ($urandom_range(7, 0))
      0: return NirDurW'(lo);
      1: return NirDurW'(hi);
      default: return NirDurW'($urandom_range(hi, lo));
    endcase
  endfunction

  // Leader, 32 payload bits, then filler; bad_pos garbles one symbol
  task automatic send_nec_frame(input logic [15:0] addr, input logic [15:0] cmd,
                                input int bad_pos, input int len);
    logic [31:0]  payload;
    in_item_t     it;
    payload = {cmd, addr};
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        it.mark_duration  = pick_near(leader_mark_q);
        it.space_duration = pick_near(leader_space_q);
      end else if (i <= 2 * NirHalfBits) begin
        it.mark_duration  = pick_near(bit_mark_q);
        it.space_duration = pick_near(payload[i-1] ? one_space_q : zero_space_q);
      end else begin
        it.mark_duration  = NirDurW'($urandom);
        it.space_duration = NirDurW'($urandom);
      end
      if (i == bad_pos) begin
        it.mark_duration  = NirDurW'($urandom);
        it.space_duration = NirDurW'($urandom);
      end
      it.last_symbol = (i == len - 1);
      send_symbol(it);
    end
  endtask

  task automatic send_repeat_frame(input int len);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        it.mark_duration  = pick_near(leader_mark_q);
        it.space_duration = pick_near(repeat_space_q);
      end else begin
        it.mark_duration  = NirDurW'($urandom);
        it.space_duration = NirDurW'($urandom);
      end
      it.last_symbol = (i == len - 1);
      send_symbol(it);
    end
  endtask

  task automatic send_noise_frame(input int len);
    for (int i = 0; i < len; i++)
      send_symbol('{NirDurW'($urandom), NirDurW'($urandom), i == len - 1});
  endtask

  task automatic test_default_frames();
    send_nec_frame(16'h0000, 16'h0000, -1, NirFullSymbols);
    send_nec_frame(16'hFFFF, 16'hFFFF, -1, NirFullSymbols);
    send_repeat_frame(2);
    send_repeat_frame(3);
    // Final symbol of a full frame goes unchecked
    send_nec_frame(16'hA5A5, 16'h5A5A, 33, NirFullSymbols);
    send_nec_frame(16'h1234, 16'h8001, 32, NirFullSymbols);
    send_nec_frame(16'h00FF, 16'hFF00, -1, 33);
    send_nec_frame(16'h00FF, 16'hFF00, -1, 35);
    // Overlong: count saturates and extra symbols are dropped
    send_nec_frame(16'hBEEF, 16'hCAFE, -1, 70);
    send_repeat_frame(2);
    wait_idle();
  endtask

  task automatic test_window_edges();
    send_symbol('{15'd9199, 15'd2449, 1'b0});
    send_symbol('{15'd0, 15'h7FFF, 1'b1});
    send_symbol('{15'd8801, 15'd2051, 1'b0});
    send_symbol('{15'h7FFF, 15'd0, 1'b1});
    send_symbol('{15'd9200, 15'd2250, 1'b0});
    send_symbol('{15'd9000, 15'd2250, 1'b1});
    send_symbol('{15'd9000, 15'd2050, 1'b0});
    send_symbol('{15'd9000, 15'd2250, 1'b1});
    send_symbol('{15'd9000, 15'd2250, 1'b1});
    wait_idle();
  endtask

  task automatic test_timing_extremes();
    // Zero tolerance: nothing can match
    write_reg(CfgTolerance, 0);
    send_nec_frame(16'h5555, 16'hAAAA, -1, NirFullSymbols);
    send_repeat_frame(2);
    wait_idle();
    // Upper write bits ignored; wide tolerance, top specs, overlapping bit windows
    set_timing(32'h7FFF, 32767, 32767, 1023, 5000, 2000, 4000);
    send_nec_frame(16'hC3C3, 16'h3C3C, -1, NirFullSymbols);
    send_repeat_frame(2);
    send_nec_frame(16'h0001, 16'h8000, -1, NirFullSymbols);
    wait_idle();
    // Tolerance above the leader space: the lower bound wraps
    write_reg(CfgLeaderSpace, 0);
    send_nec_frame(16'h7777, 16'h1111, -1, NirFullSymbols);
    send_repeat_frame(2);
    wait_idle();
    // Leader and repeat space equal: first symbol is both
    set_timing(100, 500, 3000, 3000, 300, 600, 900);
    send_repeat_frame(2);
    send_nec_frame(16'h9E37, 16'h79B9, -1, NirFullSymbols);
    wait_idle();
    set_timing(0, 0, 0, 0, 0, 0, 0);
    send_noise_frame(2);
    send_nec_frame(16'hFFFF, 16'h0000, -1, NirFullSymbols);
    wait_idle();
    set_timing(NirRstTolerance, NirRstLeaderMark, NirRstLeaderSpace, NirRstRepeatSpace,
               NirRstBitMark, NirRstZeroSpace, NirRstOneSpace);
  endtask

  // Hold the output long enough that the decoder fills and stalls its input
  task automatic test_output_holdoff();
    gap_max   = 0;
    stall_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 30; i++) send_repeat_frame(2);
    send_nec_frame(16'h2468, 16'h1357, -1, NirFullSymbols);
    wait_idle();
  endtask

  task automatic load_random_timing();
    int unsigned tol;
    int unsigned zs;
    case ($urandom_range(3, 0))
      0: set_timing(NirRstTolerance, NirRstLeaderMark, NirRstLeaderSpace,
                    NirRstRepeatSpace, NirRstBitMark, NirRstZeroSpace, NirRstOneSpace);
      1: set_timing($urandom_range(1023, 0), $urandom_range(32767, 0),
                    $urandom_range(32767, 0), $urandom_range(32767, 0),
                    $urandom_range(32767, 0), $urandom_range(32767, 0),
                    $urandom_range(32767, 0));
      default: begin
        tol = $urandom_range(600, 20);
        zs  = $urandom_range(20000, 700);
        set_timing(tol, $urandom_range(32767, 1000), $urandom_range(32767, 700),
                   $urandom_range(32767, 700), $urandom_range(20000, 700), zs,
                   zs + $urandom_range(3 * tol, 0));
      end
    endcase
  endtask

  task automatic test_random_frames(input int unsigned n);
    int unsigned first;
    int unsigned frames;
    int unsigned pick;
    first  = items_sent;
    frames = 0;
    while (items_sent - first < n) begin
      if (frames % 8 == 0) begin
        wait_idle();
        load_random_timing();
        case ($urandom_range(2, 0))
          0: gap_max = 0;
          1: gap_max = 2;
          default: gap_max = 8;
        endcase
        case ($urandom_range(2, 0))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      pick = $urandom_range(99, 0);
      if (pick < 55)
        send_nec_frame(16'($urandom), 16'($urandom), -1, NirFullSymbols);
      else if (pick < 70)
        send_repeat_frame(2);
      else if (pick < 80)
        send_nec_frame(16'($urandom), 16'($urandom), $urandom_range(33, 0), NirFullSymbols);
      else if (pick < 88)
        send_nec_frame(16'($urandom), 16'($urandom), -1, $urandom_range(40, 1));
      else if (pick < 92)
        send_repeat_frame($urandom_range(4, 1));
      else
        send_noise_frame($urandom_range(70, 1));
      frames++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_frames();
    test_window_edges();
    test_timing_extremes();
    test_output_holdoff();
    test_random_frames(1350);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
